// ----- design/ray_sphere_intersect_top_assert.svh -----
// Assertion macros for the ray-sphere intersection block.
// Included by the RTL files that check their own pipeline behavior.
`ifndef RAY_SPHERE_INTERSECT_TOP_ASSERT_SVH
`define RAY_SPHERE_INTERSECT_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define RSI_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("rsi assertion failed");
`define RSI_ASSERT_NORST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("rsi assertion failed");
`else
`define RSI_ASSERT(lbl, clk, rstn, prop)
`define RSI_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

// ----- design/rsi_pkg.sv -----
// Shared constants for the ray-sphere intersection pipeline.
// No dependencies; used by the top level and its multiplier.
`default_nettype none
package rsi_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int MUL_DIGIT       = 16;
    localparam int NUM_IN_FIELDS   = 10;
endpackage
`default_nettype wire

// ----- design/ray_sphere_intersect_top.sv -----
// Top level of the ray-sphere intersection pipeline.
// Depends on rsi_pkg, rsi_umul, rsi_div and the assertion macro header.
//
// Usage: one beat on the s_ channel carries a sphere and a ray; one beat on
// the m_ channel returns the hit flag, the nearer root distance and a flag
// for a clamped distance. Results leave in input order, one per input beat.
// Throughput: one beat per cycle while m_tready does not stall the output;
// every stage is a register and an item can enter each cycle. The pipeline
// depth is set by the square root, which retires one root bit per stage,
// and the divider, which retires one quotient bit per stage.
// Reset clears all valid bits; the pipeline is empty and ready after it.
// When the receiver holds m_tready low with a beat on m_tdata, the whole
// pipeline holds and s_tready drops; bubbles in the pipeline stay in place.
`default_nettype none
`include "ray_sphere_intersect_top_assert.svh"
module ray_sphere_intersect_top #(
    parameter int COORD_WIDTH = rsi_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rsi_pkg::FRAC_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // center_x, center_y, center_z, sphere_radius, origin_x, origin_y,
    // origin_z, dir_x, dir_y, dir_z
    input  logic [((rsi_pkg::NUM_IN_FIELDS*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // hit_distance
    output logic [((COORD_WIDTH+7)/8)*8-1:0] m_tdata,
    // is_hit, was_saturated
    output logic [1:0] m_tuser
);
    localparam int W      = COORD_WIDTH;
    localparam int NF     = rsi_pkg::NUM_IN_FIELDS;
    localparam int OUT_DW = ((W + 7) / 8) * 8;
    localparam int OW     = W + 1;
    localparam int PDW    = 2 * W;
    localparam int POW    = 2 * W + 1;
    localparam int PSW    = 2 * W + 2;
    localparam int AW     = 2 * W;
    localparam int HBW    = 2 * W + 2;
    localparam int CW     = 2 * W + 3;
    localparam int MAGW   = 2 * W + 2;
    localparam int DW     = 2 * MAGW;
    localparam int RW     = MAGW;
    localparam int RMW    = RW + 3;
    localparam int NMW    = 2 * W + 4;
    localparam int MW     = 2 * W + 3;
    localparam int QW     = W + 1;
    localparam int SW0    = HBW + AW + 1;
    localparam logic [QW:0]  NEG_LIM = (QW+1)'(1) << (W - 1);
    localparam logic [QW:0]  POS_LIM = NEG_LIM - 1'b1;
    localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] NEG_MIN = {1'b1, {(W-1){1'b0}}};

    logic en;
    logic signed [W-1:0] in_fld [NF];

    for (genvar k = 0; k < NF; k++) begin : g_fld
        assign in_fld[k] = s_tdata[k*W +: W];
    end

    logic vout_reg;
    assign en       = !vout_reg || m_tready;
    assign s_tready = en;

    // offset from center to origin
    logic                 v1_reg;
    logic signed [OW-1:0] oc_reg  [3];
    logic signed [W-1:0]  dir_reg [3];
    logic signed [W-1:0]  rad_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                oc_reg[k]  <= OW'(in_fld[4+k]) - OW'(in_fld[k]);
                dir_reg[k] <= in_fld[7+k];
            end
            rad_reg <= in_fld[3];
        end
    end

    // products
    logic                  v2_reg;
    logic signed [PDW-1:0] dd_reg [3];
    logic signed [POW-1:0] od_reg [3];
    logic signed [PSW-1:0] oo_reg [3];
    logic signed [PDW-1:0] rr_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                dd_reg[k] <= dir_reg[k] * dir_reg[k];
                od_reg[k] <= oc_reg[k] * dir_reg[k];
                oo_reg[k] <= oc_reg[k] * oc_reg[k];
            end
            rr_reg <= rad_reg * rad_reg;
        end
    end

    // quadratic coefficients
    logic                  v3_reg;
    logic signed [PSW-1:0] a_sum;
    logic [AW-1:0]         a3_reg;
    logic signed [HBW-1:0] hb3_reg;
    logic signed [CW-1:0]  c3_reg;

    assign a_sum = PSW'(dd_reg[0]) + PSW'(dd_reg[1]) + PSW'(dd_reg[2]);

    always_ff @(posedge aclk) begin
        if (en) begin
            a3_reg  <= a_sum[AW-1:0];
            hb3_reg <= HBW'(od_reg[0]) + HBW'(od_reg[1]) + HBW'(od_reg[2]);
            c3_reg  <= CW'(oo_reg[0]) + CW'(oo_reg[1]) + CW'(oo_reg[2]) - CW'(rr_reg);
        end
    end

    // magnitudes for the unsigned multipliers
    logic                  v4_reg;
    logic signed [HBW-1:0] hb_neg;
    logic signed [CW-1:0]  c_neg;
    logic [MAGW-1:0]       hbm4_reg;
    logic [MAGW-1:0]       cm4_reg;
    logic signed [HBW-1:0] hb4_reg;
    logic [AW-1:0]         a4_reg;
    logic                  az4_reg;
    logic                  cn4_reg;

    assign hb_neg = -hb3_reg;
    assign c_neg  = -c3_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            hbm4_reg <= hb3_reg[HBW-1] ? hb_neg : hb3_reg;
            cm4_reg  <= c3_reg[CW-1] ? c_neg[MAGW-1:0] : c3_reg[MAGW-1:0];
            hb4_reg  <= hb3_reg;
            a4_reg   <= a3_reg;
            az4_reg  <= a3_reg == '0;
            cn4_reg  <= c3_reg[CW-1];
        end
    end

    // half_b squared and a times c
    logic            mul0_valid;
    logic            mul1_valid;
    logic [DW-1:0]   p0;
    logic [DW-1:0]   p1;
    logic [SW0-1:0]  side0;
    logic [0:0]      side1;

    rsi_umul #(.AW(MAGW), .BW(MAGW), .DG(rsi_pkg::MUL_DIGIT), .SW(SW0)) u_mul_hb (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (v4_reg),
        .a_in     (hbm4_reg),
        .b_in     (hbm4_reg),
        .side_in  ({hb4_reg, a4_reg, az4_reg}),
        .out_valid(mul0_valid),
        .prod     (p0),
        .side_out (side0)
    );

    rsi_umul #(.AW(MAGW), .BW(MAGW), .DG(rsi_pkg::MUL_DIGIT), .SW(1)) u_mul_ac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (v4_reg),
        .a_in     (MAGW'(a4_reg)),
        .b_in     (cm4_reg),
        .side_in  (cn4_reg),
        .out_valid(mul1_valid),
        .prod     (p1),
        .side_out (side1)
    );

    // discriminant
    logic [DW-1:0] disc_c;
    assign disc_c = side1[0] ? p0 + p1 : p0 - p1;

    // square root, one root bit per stage; stage 0 is the discriminant register
    logic [RW:0]           sq_v;
    logic [DW-1:0]         sq_rad_reg  [RW];
    logic [RMW-1:0]        sq_rem_reg  [RW+1];
    logic [RW-1:0]         sq_root_reg [RW+1];
    logic signed [HBW-1:0] sq_hb_reg   [RW+1];
    logic [AW-1:0]         sq_a_reg    [RW+1];
    logic [RW:0]           sq_miss_reg;
    logic [RMW-1:0]        sq_pre      [RW];
    logic [RMW-1:0]        sq_trial    [RW];
    logic [RMW-1:0]        sq_rem_next [RW];
    logic [RW-1:0]         sq_root_next[RW];

    always_comb begin
        for (int k = 0; k < RW; k++) begin
            sq_pre[k]   = {sq_rem_reg[k][RMW-3:0], sq_rad_reg[k][DW-1 -: 2]};
            sq_trial[k] = {1'b0, sq_root_reg[k], 2'b01};
            if (sq_pre[k] >= sq_trial[k]) begin
                sq_rem_next[k]  = sq_pre[k] - sq_trial[k];
                sq_root_next[k] = {sq_root_reg[k][RW-2:0], 1'b1};
            end else begin
                sq_rem_next[k]  = sq_pre[k];
                sq_root_next[k] = {sq_root_reg[k][RW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_rad_reg[0]  <= disc_c;
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            sq_hb_reg[0]   <= $signed(side0[SW0-1 -: HBW]);
            sq_a_reg[0]    <= side0[AW:1];
            sq_miss_reg[0] <= side0[0] || disc_c[DW-1];
            for (int k = 0; k < RW; k++) begin
                if (k < RW - 1) begin
                    sq_rad_reg[k+1] <= sq_rad_reg[k] << 2;
                end
                sq_rem_reg[k+1]  <= sq_rem_next[k];
                sq_root_reg[k+1] <= sq_root_next[k];
                sq_hb_reg[k+1]   <= sq_hb_reg[k];
                sq_a_reg[k+1]    <= sq_a_reg[k];
                sq_miss_reg[k+1] <= sq_miss_reg[k];
            end
        end
    end

    // numerator -half_b - root
    logic                  v5_reg;
    logic signed [NMW-1:0] num5_reg;
    logic [AW-1:0]         a5_reg;
    logic                  miss5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            num5_reg  <= -NMW'(sq_hb_reg[RW]) - $signed(NMW'(sq_root_reg[RW]));
            a5_reg    <= sq_a_reg[RW];
            miss5_reg <= sq_miss_reg[RW];
        end
    end

    logic                  v6_reg;
    logic signed [NMW-1:0] num_neg;
    logic [MW-1:0]         mag6_reg;
    logic                  neg6_reg;
    logic [AW-1:0]         a6_reg;
    logic                  miss6_reg;

    assign num_neg = -num5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            mag6_reg  <= num5_reg[NMW-1] ? num_neg[MW-1:0] : num5_reg[MW-1:0];
            neg6_reg  <= num5_reg[NMW-1];
            a6_reg    <= a5_reg;
            miss6_reg <= miss5_reg;
        end
    end

    // division by a
    logic          dv_valid;
    logic [QW-1:0] dq;
    logic          dinx;
    logic          dovf;
    logic [1:0]    dside;

    rsi_div #(.MW(MW), .AW(AW), .FB(FRAC_BITS), .QW(QW), .SW(2)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (v6_reg),
        .mag      (mag6_reg),
        .dvs      (a6_reg),
        .side_in  ({neg6_reg, miss6_reg}),
        .out_valid(dv_valid),
        .quo      (dq),
        .inexact  (dinx),
        .ovf      (dovf),
        .side_out (dside)
    );

    // sign, floor and clamp
    logic [QW:0]  qinc;
    logic         hit_c;
    logic [W-1:0] dist_c;
    logic         sat_c;

    assign qinc = {1'b0, dq} + (QW+1)'(dinx);

    always_comb begin
        hit_c  = 1'b0;
        dist_c = '0;
        sat_c  = 1'b0;
        if (!dside[0]) begin
            hit_c = 1'b1;
            if (dside[1]) begin
                if (dovf || qinc > NEG_LIM) begin
                    dist_c = NEG_MIN;
                    sat_c  = 1'b1;
                end else begin
                    dist_c = -qinc[W-1:0];
                end
            end else begin
                if (dovf || {1'b0, dq} > POS_LIM) begin
                    dist_c = POS_MAX;
                    sat_c  = 1'b1;
                end else begin
                    dist_c = dq[W-1:0];
                end
            end
        end
    end

    logic         hit_reg;
    logic [W-1:0] dist_reg;
    logic         sat_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            hit_reg  <= hit_c;
            dist_reg <= dist_c;
            sat_reg  <= sat_c;
        end
    end

    // valid bits for the stages held in this module
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            sq_v     <= '0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end else if (en) begin
            v1_reg   <= s_tvalid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            sq_v     <= {sq_v[RW-1:0], mul0_valid};
            v5_reg   <= sq_v[RW];
            v6_reg   <= v5_reg;
            vout_reg <= dv_valid;
        end
    end

    assign m_tvalid = vout_reg;
    assign m_tdata  = OUT_DW'(dist_reg);
    assign m_tuser  = {sat_reg, hit_reg};

    `RSI_ASSERT(a_mul_lockstep, aclk, aresetn, mul0_valid == mul1_valid)
    `RSI_ASSERT(a_miss_zero, aclk, aresetn, (vout_reg && !hit_reg) |-> (dist_reg == '0 && !sat_reg))
    `RSI_ASSERT(a_sat_extreme, aclk, aresetn, (vout_reg && sat_reg) |-> (dist_reg == POS_MAX || dist_reg == NEG_MIN))
endmodule
`default_nettype wire

// ----- design/rsi_umul.sv -----
// Pipelined unsigned multiplier, one multiplier digit per stage.
// Depends on rsi_pkg for the default digit width.
`default_nettype none
module rsi_umul #(
    parameter int AW = 66,
    parameter int BW = 66,
    parameter int DG = rsi_pkg::MUL_DIGIT,
    parameter int SW = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [AW-1:0]    a_in,
    input  logic [BW-1:0]    b_in,
    input  logic [SW-1:0]    side_in,
    output logic             out_valid,
    output logic [AW+BW-1:0] prod,
    output logic [SW-1:0]    side_out
);
    localparam int ND  = (BW + DG - 1) / DG;
    localparam int BPW = ND * DG;
    localparam int PW  = AW + BW;

    logic [ND-1:0]    v_reg;
    logic [AW-1:0]    a_reg    [ND];
    logic [BPW-1:0]   b_reg    [ND];
    logic [PW-1:0]    acc_reg  [ND];
    logic [SW-1:0]    side_reg [ND];

    logic [ND-1:0]    src_v;
    logic [AW-1:0]    src_a    [ND];
    logic [BPW-1:0]   src_b    [ND];
    logic [PW-1:0]    src_acc  [ND];
    logic [SW-1:0]    src_side [ND];
    logic [AW+DG-1:0] pp       [ND];
    logic [PW-1:0]    acc_next [ND];

    assign src_v[0]    = in_valid;
    assign src_a[0]    = a_in;
    assign src_b[0]    = BPW'(b_in);
    assign src_acc[0]  = '0;
    assign src_side[0] = side_in;

    for (genvar k = 1; k < ND; k++) begin : g_src
        assign src_v[k]    = v_reg[k-1];
        assign src_a[k]    = a_reg[k-1];
        assign src_b[k]    = b_reg[k-1];
        assign src_acc[k]  = acc_reg[k-1];
        assign src_side[k] = side_reg[k-1];
    end

    always_comb begin
        for (int k = 0; k < ND; k++) begin
            pp[k]       = src_a[k] * src_b[k][k*DG +: DG];
            acc_next[k] = src_acc[k] + (PW'(pp[k]) << (k * DG));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= src_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < ND; k++) begin
                a_reg[k]    <= src_a[k];
                b_reg[k]    <= src_b[k];
                acc_reg[k]  <= acc_next[k];
                side_reg[k] <= src_side[k];
            end
        end
    end

    assign out_valid = v_reg[ND-1];
    assign prod      = acc_reg[ND-1];
    assign side_out  = side_reg[ND-1];
endmodule
`default_nettype wire

// ----- design/rsi_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
// Standalone; instantiated by the top level for the root distance.
`default_nettype none
module rsi_div #(
    parameter int MW = 67,
    parameter int AW = 64,
    parameter int FB = 16,
    parameter int QW = 33,
    parameter int SW = 2
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [MW-1:0] mag,
    input  logic [AW-1:0] dvs,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [QW-1:0] quo,
    output logic          inexact,
    output logic          ovf,
    output logic [SW-1:0] side_out
);
    localparam int NW  = MW + FB;
    localparam int NHW = NW - QW;
    localparam int CMW = (NHW > AW) ? NHW : AW;

    logic [NW-1:0]  num_full;
    logic [CMW-1:0] nhi_x;
    logic           ovf_c;

    logic           v0_reg;
    logic [AW-1:0]  rem0_reg;
    logic [QW-1:0]  lo0_reg;
    logic [AW-1:0]  d0_reg;
    logic           ovf0_reg;
    logic [SW-1:0]  side0_reg;

    logic [QW-1:0]  v_reg;
    logic [AW-1:0]  rem_reg  [QW];
    logic [QW-1:0]  lo_reg   [QW];
    logic [QW-1:0]  q_reg    [QW];
    logic [AW-1:0]  d_reg    [QW];
    logic [QW-1:0]  ovf_reg;
    logic [SW-1:0]  side_reg [QW];

    logic [QW-1:0]  src_v;
    logic [AW-1:0]  src_rem  [QW];
    logic [QW-1:0]  src_lo   [QW];
    logic [QW-1:0]  src_q    [QW];
    logic [AW-1:0]  src_d    [QW];
    logic [QW-1:0]  src_ovf;
    logic [SW-1:0]  src_side [QW];

    logic [AW:0]    pre      [QW];
    logic [AW:0]    diff     [QW];
    logic [QW-1:0]  ge;
    logic [AW-1:0]  rem_next [QW];

    assign num_full = {mag, {FB{1'b0}}};
    assign nhi_x    = CMW'(num_full[NW-1:QW]);
    assign ovf_c    = nhi_x >= CMW'(dvs);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (en) begin
            v0_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem0_reg  <= nhi_x[AW-1:0];
            lo0_reg   <= num_full[QW-1:0];
            d0_reg    <= dvs;
            ovf0_reg  <= ovf_c;
            side0_reg <= side_in;
        end
    end

    assign src_v[0]    = v0_reg;
    assign src_rem[0]  = rem0_reg;
    assign src_lo[0]   = lo0_reg;
    assign src_q[0]    = '0;
    assign src_d[0]    = d0_reg;
    assign src_ovf[0]  = ovf0_reg;
    assign src_side[0] = side0_reg;

    for (genvar k = 1; k < QW; k++) begin : g_src
        assign src_v[k]    = v_reg[k-1];
        assign src_rem[k]  = rem_reg[k-1];
        assign src_lo[k]   = lo_reg[k-1];
        assign src_q[k]    = q_reg[k-1];
        assign src_d[k]    = d_reg[k-1];
        assign src_ovf[k]  = ovf_reg[k-1];
        assign src_side[k] = side_reg[k-1];
    end

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            pre[k]      = {src_rem[k], src_lo[k][QW-1]};
            diff[k]     = pre[k] - {1'b0, src_d[k]};
            ge[k]       = pre[k] >= {1'b0, src_d[k]};
            rem_next[k] = ge[k] ? diff[k][AW-1:0] : pre[k][AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= src_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ovf_reg <= src_ovf;
            for (int k = 0; k < QW; k++) begin
                rem_reg[k]  <= rem_next[k];
                lo_reg[k]   <= src_lo[k] << 1;
                q_reg[k]    <= {src_q[k][QW-2:0], ge[k]};
                d_reg[k]    <= src_d[k];
                side_reg[k] <= src_side[k];
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign quo       = q_reg[QW-1];
    assign inexact   = rem_reg[QW-1] != '0;
    assign ovf       = ovf_reg[QW-1];
    assign side_out  = side_reg[QW-1];
endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for ray_sphere_intersect_top: directed table then random beats,
// checked against table results or an exact wide-integer intersection predictor.
// Depends on rsi_pkg and the ray_sphere_intersect_top RTL.
`timescale 1ns / 100ps
module tb;
    localparam int W      = rsi_pkg::COORD_WIDTH_DEF;
    localparam int FB     = rsi_pkg::FRAC_BITS_DEF;
    localparam int NF     = rsi_pkg::NUM_IN_FIELDS;
    localparam int DW     = NF * W;
    localparam int LAT    = 3 * W + 12 + (2 * W + 2 + 15) / 16;
    localparam int N_RAND = 450;
    localparam int WD_MAX = 5000;
    localparam logic [W-1:0] ONE = 32'h0001_0000;

    typedef struct packed {
        logic         hit;
        logic [W-1:0] hit_dist;
        logic         sat;
    } hit_t;

    typedef struct {
        logic [DW-1:0] data;
        bit            known;
        hit_t          res;
    } row_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [W-1:0]  m_tdata;
    logic [1:0]    m_tuser;

    hit_t hit_q[$];
    bit   idle_on = 1'b1;
    int   errors = 0;
    int   n_sent = 0;
    int   n_got = 0;
    int   n_hit = 0;
    int   n_sat = 0;
    int   wd_cnt = 0;

    ray_sphere_intersect_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic [DW-1:0] pack_ray(
        input logic [W-1:0] cx, cy, cz, r, ox, oy, oz, dx, dy, dz);
        pack_ray = {dz, dy, dx, oz, oy, ox, r, cz, cy, cx};
    endfunction

    function automatic hit_t ray_hit(input logic [DW-1:0] d);
        logic signed [255:0] f[NF];
        logic signed [255:0] ocx, ocy, ocz, a, hb, c, disc, num, qs;
        logic [255:0] rt, tr, mag, qu, rm;
        hit_t r;
        for (int i = 0; i < NF; i++) f[i] = $signed(d[i*W +: W]);
        ocx = f[4] - f[0];
        ocy = f[5] - f[1];
        ocz = f[6] - f[2];
        a = f[7] * f[7] + f[8] * f[8] + f[9] * f[9];
        hb = ocx * f[7] + ocy * f[8] + ocz * f[9];
        c = ocx * ocx + ocy * ocy + ocz * ocz - f[3] * f[3];
        disc = hb * hb - a * c;
        r = '0;
        if (a == 0 || disc < 0) return r;
        rt = '0;
        for (int b = 127; b >= 0; b--) begin
            tr = rt | (256'd1 << b);
            if (tr * tr <= $unsigned(disc)) rt = tr;
        end
        num = (-hb - $signed(rt)) <<< FB;
        mag = (num < 0) ? $unsigned(-num) : $unsigned(num);
        qu = mag / $unsigned(a);
        rm = mag % $unsigned(a);
        qs = (num < 0) ? -$signed(qu + (rm != 0)) : $signed(qu);
        r.hit = 1'b1;
        if (qs > $signed(256'h7FFF_FFFF)) begin
            qs = 256'h7FFF_FFFF;
            r.sat = 1'b1;
        end else if (qs < -$signed(256'h8000_0000)) begin
            qs = -$signed(256'h8000_0000);
            r.sat = 1'b1;
        end
        r.hit_dist = qs[W-1:0];
        return r;
    endfunction

    function automatic logic [W-1:0] rand_coord();
        logic [W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $urandom >> $urandom_range(8, 31);
            default: v = ($urandom >> $urandom_range(12, 20));
        endcase
        if ($urandom_range(0, 1)) v = -v;
        return v;
    endfunction

    task automatic send_beat(input logic [DW-1:0] d, input hit_t res);
        while (idle_on && $urandom_range(0, 99) < 22) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        hit_q.push_back(res);
        n_sent++;
    endtask

    always @(posedge aclk) begin
        m_tready <= !idle_on || ($urandom_range(0, 99) >= 22);
        if (aresetn && m_tvalid && m_tready) begin
            if (hit_q.size() == 0) begin
                $display("%0t: unexpected beat tdata=%h tuser=%b", $time, m_tdata, m_tuser);
                errors++;
            end else begin
                hit_t e;
                e = hit_q.pop_front();
                n_got++;
                if (m_tuser[0]) n_hit++;
                if (m_tuser[1]) n_sat++;
                if (m_tuser[0] !== e.hit) begin
                    $display("%0t: is_hit exp %b got %b", $time, e.hit, m_tuser[0]);
                    errors++;
                end
                if (m_tdata !== e.hit_dist) begin
                    $display("%0t: hit_distance exp %h got %h", $time, e.hit_dist, m_tdata);
                    errors++;
                end
                if (m_tuser[1] !== e.sat) begin
                    $display("%0t: was_saturated exp %b got %b", $time, e.sat, m_tuser[1]);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            wd_cnt <= 0;
        end else begin
            wd_cnt <= wd_cnt + 1;
            if (wd_cnt >= WD_MAX) begin
                $display("%0t: watchdog expired, %0d beats outstanding", $time, hit_q.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        row_t rows[$];
        row_t rw;
        logic [DW-1:0] d;
        logic [W-1:0] mx, mn;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;

        // zero direction: miss
        rw.data = '0; rw.known = 1; rw.res = '0; rows.push_back(rw);
        // plain hit ahead at t = 4.0
        rw.data = pack_ray(0, 0, 5 * ONE, ONE, 0, 0, 0, 0, 0, ONE);
        rw.res = '{1'b1, 4 * ONE, 1'b0}; rows.push_back(rw);
        // negative radius: same as its magnitude
        rw.data = pack_ray(0, 0, 5 * ONE, -ONE, 0, 0, 0, 0, 0, ONE); rows.push_back(rw);
        // sphere behind origin: negative t
        rw.data = pack_ray(0, 0, -5 * ONE, ONE, 0, 0, 0, 0, 0, ONE);
        rw.res = '{1'b1, -6 * ONE, 1'b0}; rows.push_back(rw);
        // negative discriminant: miss
        rw.data = pack_ray(0, 5 * ONE, 5 * ONE, ONE, 0, 0, 0, 0, 0, ONE);
        rw.res = '0; rows.push_back(rw);
        // zero direction with origin inside sphere: still a miss
        rw.data = pack_ray(0, 0, 0, 4 * ONE, ONE, 0, 0, 0, 0, 0); rows.push_back(rw);
        rw.known = 0;
        rw.data = pack_ray(0, 0, mx, ONE, 0, 0, 0, 0, 0, 1); rows.push_back(rw);
        rw.data = pack_ray(0, 0, mn, ONE, 0, 0, 0, 0, 0, 1); rows.push_back(rw);
        rw.data = pack_ray(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx); rows.push_back(rw);
        rw.data = pack_ray(mn, mn, mn, mn, mn, mn, mn, mn, mn, mn); rows.push_back(rw);
        rw.data = pack_ray(mn, mn, mn, mx, mx, mx, mx, mn, mn, mn); rows.push_back(rw);
        rw.data = pack_ray(mx, mx, mx, mn, mn, mn, mn, mx, mx, mx); rows.push_back(rw);
        rw.data = pack_ray(0, 0, 0, mx, 0, 0, 0, 1, 0, 0); rows.push_back(rw);
        rw.data = pack_ray(0, 0, 3 * ONE, ONE, 0, ONE, 0, 0, 0, ONE); rows.push_back(rw);
        rw.data = pack_ray(ONE, 2 * ONE, 3 * ONE, 2 * ONE, 0, 0, 0, ONE, ONE, ONE);
        rows.push_back(rw);
        rw.data = {DW{1'b1}}; rows.push_back(rw);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            send_beat(rows[i].data, rows[i].known ? rows[i].res : ray_hit(rows[i].data));
        end

        // hold input until the pipeline drains
        s_tvalid <= 1'b0;
        wait (hit_q.size() == 0);
        @(posedge aclk);

        for (int n = 0; n < N_RAND; n++) begin
            idle_on = !(n >= 200 && n < 300);
            if ($urandom_range(0, 9) < 2) begin
                for (int k = 0; k < DW / 32; k++) d[k*32 +: 32] = $urandom;
            end else begin
                for (int k = 0; k < NF; k++) d[k*W +: W] = rand_coord();
                if ($urandom_range(0, 19) == 0) d[7*W +: 3*W] = '0;
            end
            send_beat(d, ray_hit(d));
        end
        s_tvalid <= 1'b0;
        idle_on = 1'b1;

        wait (hit_q.size() == 0);
        repeat (LAT + 20) @(posedge aclk);

        $display("Sent %0d rays (directed extremes, misses, behind-origin, saturation, random);",
                 n_sent);
        $display("received %0d results, %0d hits, %0d saturated.", n_got, n_hit, n_sat);
        if (errors == 0 && hit_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+design
design/rsi_pkg.sv
design/rsi_umul.sv
design/rsi_div.sv
design/ray_sphere_intersect_top.sv
sim/tb.sv
